/* rtl/byc_pkg.sv */
package byc_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned POS_W = $clog2(MAX_DIMENSION);
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned ACC_W = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RESET_FRAME_WIDTH = 13'd1920;
  localparam logic [CFG_DATA_W-1:0] RESET_FRAME_HEIGHT = 13'd1080;

  localparam logic signed [ACC_W-1:0] Y_R = 18'sd66;
  localparam logic signed [ACC_W-1:0] Y_G = 18'sd129;
  localparam logic signed [ACC_W-1:0] Y_B = 18'sd25;
  localparam logic signed [ACC_W-1:0] Y_OFS = 18'sd16;
  localparam logic signed [ACC_W-1:0] CB_R = -18'sd38;
  localparam logic signed [ACC_W-1:0] CB_G = -18'sd74;
  localparam logic signed [ACC_W-1:0] CB_B = 18'sd112;
  localparam logic signed [ACC_W-1:0] CR_R = 18'sd112;
  localparam logic signed [ACC_W-1:0] CR_G = -18'sd94;
  localparam logic signed [ACC_W-1:0] CR_B = -18'sd18;
  localparam logic signed [ACC_W-1:0] C_OFS = 18'sd128;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] blue_difference;
    logic [PIX_W-1:0] red_difference;
  } byc_color_t;

  function automatic logic [PIX_W-1:0] weigh(input logic signed [ACC_W-1:0] sum,
                                             input logic signed [ACC_W-1:0] offset);
    logic signed [ACC_W-1:0] biased;
    biased = sum + (offset <<< 8);
    if (biased < 0) begin
      return '0;
    end
    return biased[15:8];
  endfunction

endpackage

/* rtl/bgra_to_yuv420_pixel_converter_unit.sv */
// output: an accepted item is loaded into the output register and its result is presented
//   from that register in the next cycle
// throughput: one item per cycle, set by the single output register that stalls only
//   while its result waits downstream
// reset: synchronous active-low rst_n clears the output valid and the column and line
//   counters, and loads frame width 1920 and frame height 1080
module bgra_to_yuv420_pixel_converter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [byc_pkg::PIX_W-1:0]         in_blue,
  input  logic [byc_pkg::PIX_W-1:0]         in_green,
  input  logic [byc_pkg::PIX_W-1:0]         in_red,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [byc_pkg::PIX_W-1:0]         out_luma,
  output logic                              out_chroma_valid,
  output logic [byc_pkg::PIX_W-1:0]         out_blue_difference,
  output logic [byc_pkg::PIX_W-1:0]         out_red_difference,
  output logic                              out_line_end,
  output logic                              out_frame_end,
  input  logic                              cfg_write_enable,
  input  logic [byc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [byc_pkg::CFG_DATA_W-1:0]    cfg_write_data
);
  import byc_pkg::*;

  logic [CFG_DATA_W-1:0] frame_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;
  logic [POS_W-1:0]      col_r;
  logic [POS_W-1:0]      col_nxt;
  logic [POS_W-1:0]      line_r;
  logic [POS_W-1:0]      line_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  byc_color_t            color_r;
  logic                  chroma_r;
  logic                  line_end_r;
  logic                  frame_end_r;

  logic [DIM_W-1:0]      width_use;
  logic [DIM_W-1:0]      height_use;
  logic [POS_W-1:0]      width_last;
  logic [POS_W-1:0]      height_last;
  logic                  accept;
  logic                  chroma_on;
  logic                  eol;
  logic                  eof;
  byc_color_t            color;

  always_comb begin
    width_use = frame_width_r;
    if (frame_width_r < DIM_W'(2)) begin
      width_use = DIM_W'(2);
    end else if (frame_width_r > DIM_W'(MAX_DIMENSION)) begin
      width_use = DIM_W'(MAX_DIMENSION);
    end
    height_use = frame_height_r;
    if (frame_height_r < DIM_W'(1)) begin
      height_use = DIM_W'(1);
    end else if (frame_height_r > DIM_W'(MAX_DIMENSION)) begin
      height_use = DIM_W'(MAX_DIMENSION);
    end
  end

  assign width_last = POS_W'(width_use - DIM_W'(1));
  assign height_last = POS_W'(height_use - DIM_W'(1));

  assign in_stall = out_valid_r && out_stall;
  assign accept = in_valid && !in_stall;

  assign chroma_on = !line_r[0] && !col_r[0];
  assign eol = col_r >= width_last;
  assign eof = eol && (line_r >= height_last);

  byc_color_matrix u_matrix (
    .blue      (in_blue),
    .green     (in_green),
    .red       (in_red),
    .chroma_on (chroma_on),
    .color     (color)
  );

  always_comb begin
    col_nxt = col_r;
    line_nxt = line_r;
    if (accept) begin
      if (eol) begin
        col_nxt = '0;
        line_nxt = eof ? '0 : line_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= RESET_FRAME_WIDTH;
      frame_height_r <= RESET_FRAME_HEIGHT;
      col_r <= '0;
      line_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_FRAME_WIDTH: frame_width_r <= cfg_write_data;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_write_data;
          default: ;
        endcase
      end
      col_r <= col_nxt;
      line_r <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      color_r <= color;
      chroma_r <= chroma_on;
      line_end_r <= eol;
      frame_end_r <= eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_luma = color_r.luma;
  assign out_chroma_valid = chroma_r;
  assign out_blue_difference = color_r.blue_difference;
  assign out_red_difference = color_r.red_difference;
  assign out_line_end = line_end_r;
  assign out_frame_end = frame_end_r;

  a_frame_end_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_end_r |-> line_end_r)
    else $error("frame end without line end");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !chroma_r |-> color_r.blue_difference == '0 && color_r.red_difference == '0)
    else $error("chroma difference nonzero without chroma");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && eof |=> col_r == '0 && line_r == '0)
    else $error("counters did not wrap at frame end");

endmodule

/* rtl/byc_color_matrix.sv */
module byc_color_matrix (
  input  logic [byc_pkg::PIX_W-1:0] blue,
  input  logic [byc_pkg::PIX_W-1:0] green,
  input  logic [byc_pkg::PIX_W-1:0] red,
  input  logic                      chroma_on,
  output byc_pkg::byc_color_t       color
);
  import byc_pkg::*;

  logic signed [ACC_W-1:0] b_s;
  logic signed [ACC_W-1:0] g_s;
  logic signed [ACC_W-1:0] r_s;
  logic signed [ACC_W-1:0] y_sum;
  logic signed [ACC_W-1:0] cb_sum;
  logic signed [ACC_W-1:0] cr_sum;

  assign b_s = $signed({{(ACC_W-PIX_W){1'b0}}, blue});
  assign g_s = $signed({{(ACC_W-PIX_W){1'b0}}, green});
  assign r_s = $signed({{(ACC_W-PIX_W){1'b0}}, red});

  assign y_sum = Y_R * r_s + Y_G * g_s + Y_B * b_s;
  assign cb_sum = CB_R * r_s + CB_G * g_s + CB_B * b_s;
  assign cr_sum = CR_R * r_s + CR_G * g_s + CR_B * b_s;

  always_comb begin
    color.luma = weigh(y_sum, Y_OFS);
    color.blue_difference = '0;
    color.red_difference = '0;
    if (chroma_on) begin
      color.blue_difference = weigh(cb_sum, C_OFS);
      color.red_difference = weigh(cr_sum, C_OFS);
    end
  end

endmodule
